// ===== rtl/npwr_pkg.sv =====
`timescale 1ns / 1ps

package npwr_pkg;

	localparam int MAX_POINTS = 64;
	localparam int COORD_BITS = 16;
	localparam int PTR_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int SKIP_W     = 7;
	localparam int COUNT_W    = 7;
	localparam int RADIUS_W   = 16;
	localparam int R2_W       = 2 * RADIUS_W;
	localparam int ABS_W      = COORD_BITS + 1;
	localparam int SQ_W       = 2 * ABS_W;
	localparam int DIST_W     = 34;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_COUNT  = CFG_IDX_W'(1);

	typedef struct packed {
		logic                         kind;
		logic [5:0]                   slot;
		logic signed [COORD_BITS-1:0] coord_x;
		logic signed [COORD_BITS-1:0] coord_y;
		logic signed [SKIP_W-1:0]     skip_index;
	} item_t;

	typedef struct packed {
		logic             load;
		logic             start;
		logic             issue;
		logic [PTR_W-1:0] addr;
		logic             publish;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] scan_len;
		logic             pipe_busy;
		logic             out_full;
	} sts_t;

endpackage

// ===== rtl/npwr_if.sv =====
`timescale 1ns / 1ps

interface npwr_req_if;
	import npwr_pkg::*;
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic [5:0]                   slot;
	logic signed [COORD_BITS-1:0] coord_x;
	logic signed [COORD_BITS-1:0] coord_y;
	logic signed [SKIP_W-1:0]     skip_index;
	modport source (output valid, kind, slot, coord_x, coord_y, skip_index, input ready);
	modport sink (input valid, kind, slot, coord_x, coord_y, skip_index, output ready);
endinterface

interface npwr_rsp_if;
	import npwr_pkg::*;
	logic              valid;
	logic              ready;
	logic              found;
	logic [5:0]        nearest_index;
	logic [DIST_W-1:0] distance_sq;
	modport source (output valid, found, nearest_index, distance_sq, input ready);
	modport sink (input valid, found, nearest_index, distance_sq, output ready);
endinterface

interface npwr_cfg_if;
	import npwr_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/npwr_ctrl.sv =====
`timescale 1ns / 1ps

module npwr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_kind,
	output logic          req_ready,
	input  npwr_pkg::sts_t sts,
	output npwr_pkg::cmd_t cmd
);
	import npwr_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             take;

	assign req_ready = (state_q == ST_IDLE);
	assign take      = req_valid && req_ready;

	always_comb begin
		cmd.load    = take && (req_kind == KIND_LOAD);
		cmd.start   = take && (req_kind == KIND_QUERY);
		cmd.issue   = (state_q == ST_SCAN);
		cmd.addr    = cnt_q[PTR_W-1:0];
		cmd.publish = (state_q == ST_FINISH) && !sts.out_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (take && (req_kind == KIND_QUERY)) begin
						state_q <= (sts.scan_len == '0) ? ST_DRAIN : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cnt_q + CNT_W'(1) == sts.scan_len) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_DRAIN: begin
					if (!sts.pipe_busy) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!sts.out_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/npwr_dp.sv =====
`timescale 1ns / 1ps

module npwr_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  npwr_pkg::item_t item,
	input  npwr_pkg::cmd_t  cmd,
	output npwr_pkg::sts_t  sts,
	npwr_cfg_if.sink        cfg,
	npwr_rsp_if.source      rsp
);
	import npwr_pkg::*;

	logic [2*COORD_BITS-1:0] mem [MAX_POINTS];

	logic [RADIUS_W-1:0] radius_q;
	logic [COUNT_W-1:0]  count_q;

	logic signed [COORD_BITS-1:0] qx_q, qy_q;
	logic                         skip_en_q;
	logic [PTR_W-1:0]             skip_idx_q;
	logic [R2_W-1:0]              r2_q;

	logic                    v_s1, v_s2, v_s3, v_s4;
	logic [PTR_W-1:0]        idx_s1, idx_s2, idx_s3, idx_s4;
	logic [2*COORD_BITS-1:0] pt_s1;
	logic [ABS_W-1:0]        ux_s2, uy_s2;
	logic [SQ_W-1:0]         sqx_s3, sqy_s3;
	logic [DIST_W-1:0]       d2_s4;

	logic signed [ABS_W-1:0] dx, dy;
	logic                    hit_q;
	logic [PTR_W-1:0]        best_q;
	logic [DIST_W-1:0]       best_d_q;
	logic                    better;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
			count_q  <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_RADIUS: radius_q <= cfg.data[RADIUS_W-1:0];
				REG_COUNT:  count_q  <= cfg.data[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		sts.scan_len  = (count_q > COUNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
			: CNT_W'(count_q);
		sts.pipe_busy = v_s1 || v_s2 || v_s3 || v_s4;
		sts.out_full  = rsp.valid;
	end

	// point table, registered read
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem[item.slot[PTR_W-1:0]] <= {item.coord_x, item.coord_y};
		end
		pt_s1 <= mem[cmd.addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			qx_q       <= item.coord_x;
			qy_q       <= item.coord_y;
			skip_en_q  <= !item.skip_index[SKIP_W-1];
			skip_idx_q <= item.skip_index[PTR_W-1:0];
			r2_q       <= radius_q * radius_q;
		end
	end

	assign dx = ABS_W'(qx_q) - ABS_W'($signed(pt_s1[2*COORD_BITS-1:COORD_BITS]));
	assign dy = ABS_W'(qy_q) - ABS_W'($signed(pt_s1[COORD_BITS-1:0]));

	always_ff @(posedge clk) begin
		idx_s1 <= cmd.addr;
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		idx_s4 <= idx_s3;
		ux_s2  <= dx[ABS_W-1] ? ABS_W'(-dx) : ABS_W'(dx);
		uy_s2  <= dy[ABS_W-1] ? ABS_W'(-dy) : ABS_W'(dy);
		sqx_s3 <= ux_s2 * ux_s2;
		sqy_s3 <= uy_s2 * uy_s2;
		d2_s4  <= DIST_W'({1'b0, sqx_s3} + {1'b0, sqy_s3});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue && !(skip_en_q && (cmd.addr == skip_idx_q));
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// strict less keeps the lowest index on a tie
	assign better = v_s4 && (d2_s4 <= DIST_W'(r2_q)) && (!hit_q || (d2_s4 < best_d_q));

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			hit_q    <= 1'b0;
			best_q   <= '0;
			best_d_q <= '0;
		end else if (better) begin
			hit_q    <= 1'b1;
			best_q   <= idx_s4;
			best_d_q <= d2_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (cmd.publish) begin
			rsp.valid <= 1'b1;
		end else if (rsp.ready) begin
			rsp.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			rsp.found         <= hit_q;
			rsp.nearest_index <= 6'(best_q);
			rsp.distance_sq   <= best_d_q;
		end
	end

endmodule

// ===== rtl/nearest_point_within_radius.sv =====
`timescale 1ns / 1ps
// Nearest point within radius.
// req: words of kind load (write coord_x/coord_y to table entry slot) or kind
//   query (search the first point_count entries, leaving out skip_index).
// rsp: one word per query: found, nearest_index, distance_sq (squared).
// cfg: register 0 is search_radius, register 1 is point_count; ready is
//   always high, write only while the block is idle.
// A query holds req.ready low until its result is published: one table
// read per cycle over the first min(point_count, 64) entries feeds a
// four-stage distance unit (difference, square, sum, compare), then the
// pipeline drains and the result moves to the output register.
// If rsp is stalled, a finished result waits in the output register; loads
// are still taken, and a following query completes its scan and then waits
// until the previous word has been taken.
// Reset clears both registers to 0 and empties the output register. Table
// contents are undefined until loaded; queries must only read loaded entries.

module nearest_point_within_radius (
	input  logic      clk,
	input  logic      arst_n,
	npwr_req_if.sink   req,
	npwr_rsp_if.source rsp,
	npwr_cfg_if.sink   cfg
);
	import npwr_pkg::*;

	item_t item;
	cmd_t  cmd;
	sts_t  sts;

	always_comb begin
		item.kind       = req.kind;
		item.slot       = req.slot;
		item.coord_x    = req.coord_x;
		item.coord_y    = req.coord_y;
		item.skip_index = req.skip_index;
	end

	npwr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_kind  (req.kind),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	npwr_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.cfg    (cfg),
		.rsp    (rsp)
	);

	a_idle_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !sts.pipe_busy && !cmd.issue)
		else $error("input taken while a scan is in flight");

	a_publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> !rsp.valid)
		else $error("result published over an untaken word");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) && !rsp.found |-> rsp.nearest_index == '0 && rsp.distance_sq == '0)
		else $error("miss word carries nonzero fields");

endmodule
